[hw/rtl/lpd_pkg.sv]
// Shared types and constants for the length-prefixed packet deframer.
`timescale 1ns / 1ps

package lpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 16;
    localparam int CODE_W  = 32;
    localparam int LIMIT_W = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [STAT_W-1:0]    t_status;

    // Register indexes on the configuration port
    localparam t_cfg_idx CFG_HEAD   = 2'd0;
    localparam t_cfg_idx CFG_VERIFY = 2'd1;
    localparam t_cfg_idx CFG_TAIL   = 2'd2;
    localparam t_cfg_idx CFG_MAXLEN = 2'd3;

    // Result status codes
    localparam t_status ST_BODY     = 2'd0;
    localparam t_status ST_GOOD     = 2'd1;
    localparam t_status ST_BAD_TAIL = 2'd2;
    localparam t_status ST_OVERSIZE = 2'd3;

    localparam logic [LIMIT_W-1:0] MAXLEN_RESET = 16'd256;

    typedef struct packed {
        logic [BYTE_W-1:0]  head_byte;
        logic [CODE_W-1:0]  verify_code;
        logic [BYTE_W-1:0]  tail_byte;
        logic [LIMIT_W-1:0] max_packet_len;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [INDEX_W-1:0] byte_index;
        t_status            status;
        logic               last;
    } t_result;

endpackage

[hw/rtl/lpd_rx_if.sv]
// Receive byte channel: valid/ready handshake with one byte per word.
`timescale 1ns / 1ps

interface lpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/lpd_res_if.sv]
// Result channel: valid/ready handshake carrying one tagged packet byte per word.
`timescale 1ns / 1ps

interface lpd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [15:0] byte_index;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output out_byte, output byte_index, output status,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input byte_index, input status,
                    input last, output ready);
endinterface

[hw/rtl/lpd_cfg_regs.sv]
// Configuration register file for the deframer.
`timescale 1ns / 1ps

module lpd_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  lpd_pkg::t_cfg_idx i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    output lpd_pkg::t_cfg    o_cfg
);
    import lpd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte      <= '0;
            r_cfg.verify_code    <= '0;
            r_cfg.tail_byte      <= '0;
            r_cfg.max_packet_len <= MAXLEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEAD:   r_cfg.head_byte      <= i_cfg_data[BYTE_W-1:0];
                CFG_VERIFY: r_cfg.verify_code    <= i_cfg_data[CODE_W-1:0];
                CFG_TAIL:   r_cfg.tail_byte      <= i_cfg_data[BYTE_W-1:0];
                CFG_MAXLEN: r_cfg.max_packet_len <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/lpd_in_stage.sv]
// Input register stage: holds one received byte until the core takes it.
`timescale 1ns / 1ps

module lpd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_adv,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import lpd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_load;

    assign o_ready = !r_valid || i_adv;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

[hw/rtl/lpd_core.sv]
// Deframer state machine: head hunt, verify match, header parse and body tagging.
`timescale 1ns / 1ps

module lpd_core #(
    parameter int VERIFY_BYTES = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lpd_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_adv,
    output logic             o_res_valid,
    output lpd_pkg::t_result o_res
);
    import lpd_pkg::*;

    localparam int SEQ_POS  = 1 + VERIFY_BYTES;
    localparam int LEN_POS  = SEQ_POS + 2;
    localparam int DATA_POS = LEN_POS + 4;

    localparam logic [INDEX_W-1:0] SEQ_POS_W  = INDEX_W'(SEQ_POS);
    localparam logic [INDEX_W-1:0] LEN_POS_W  = INDEX_W'(LEN_POS);
    localparam logic [INDEX_W-1:0] DATA_POS_W = INDEX_W'(DATA_POS);
    localparam logic [CODE_W:0]    FIXED_LEN  = (CODE_W+1)'(DATA_POS + 1);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_VERIFY = 2'd1;
    localparam logic [1:0] PH_HEADER = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    logic [1:0]         r_phase, n_phase;
    logic [INDEX_W-1:0] r_count, n_count;
    logic [CODE_W-1:0]  r_accum, n_accum;
    logic [LIMIT_W-1:0] r_total, n_total;

    logic [INDEX_W-1:0]  w_count_inc;
    logic [2:0]          w_vsel;
    logic [2*CODE_W-1:0] w_vword;
    logic [BYTE_W-1:0]   w_expect;
    logic [1:0]          w_lsel;
    logic [CODE_W-1:0]   w_accum_new;
    logic [CODE_W:0]     w_total;
    logic [INDEX_W:0]    w_idx_inc;
    t_result             w_res;

    assign w_count_inc = r_count + 1'b1;
    // verify bytes five to eight compare against zero; later ones wrap to the code's low bytes
    assign w_vsel   = r_count[2:0] - 3'd1;
    assign w_vword  = {{CODE_W{1'b0}}, i_cfg.verify_code};
    assign w_expect = w_vword[{w_vsel, 3'b000} +: BYTE_W];

    assign w_lsel      = r_count[1:0] - LEN_POS_W[1:0];
    assign w_accum_new = r_accum | ({{(CODE_W-BYTE_W){1'b0}}, i_byte} << {w_lsel, 3'b000});
    assign w_total     = FIXED_LEN + {1'b0, w_accum_new};
    assign w_idx_inc   = {1'b0, r_count} + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_accum = r_accum;
        n_total = r_total;
        w_res.out_byte   = i_byte;
        w_res.byte_index = r_count;
        w_res.status     = ST_BODY;
        w_res.last       = 1'b0;

        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.head_byte) begin
                    n_phase = PH_VERIFY;
                    n_count = INDEX_W'(1);
                end
            end
            PH_VERIFY: begin
                if (i_byte == w_expect) begin
                    n_count = w_count_inc;
                    if (w_count_inc >= SEQ_POS_W) begin
                        n_phase = PH_HEADER;
                        n_accum = '0;
                    end
                end else if (i_byte == i_cfg.head_byte) begin
                    n_count = INDEX_W'(1);
                end else begin
                    n_phase = PH_HUNT;
                    n_count = '0;
                    n_accum = '0;
                end
            end
            PH_HEADER: begin
                if (r_count >= LEN_POS_W && r_count < DATA_POS_W) begin
                    n_accum = w_accum_new;
                end
                n_count = w_count_inc;
                if (w_count_inc >= DATA_POS_W) begin
                    if (w_total > {{(CODE_W+1-LIMIT_W){1'b0}}, i_cfg.max_packet_len}) begin
                        w_res.status = ST_OVERSIZE;
                        w_res.last   = 1'b1;
                        n_phase = PH_HUNT;
                        n_count = '0;
                        n_accum = '0;
                    end else begin
                        // fits the limit, so the total fits in 16 bits
                        n_total = w_total[LIMIT_W-1:0];
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                n_count = w_count_inc;
                if (w_idx_inc >= {1'b0, r_total}) begin
                    w_res.status = (i_byte == i_cfg.tail_byte) ? ST_GOOD : ST_BAD_TAIL;
                    w_res.last   = 1'b1;
                    n_phase = PH_HUNT;
                    n_count = '0;
                    n_accum = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_accum <= '0;
            r_total <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_accum <= n_accum;
            r_total <= n_total;
        end
    end

    assign o_res_valid = i_valid && (r_phase == PH_HEADER || r_phase == PH_BODY);
    assign o_res       = w_res;

endmodule

[hw/rtl/lpd_out_stage.sv]
// Result register: holds one result word until the sink takes it.
`timescale 1ns / 1ps

module lpd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lpd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_free,
    output lpd_pkg::t_result o_res
);
    import lpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[hw/rtl/length_prefixed_packet_deframer.sv]
// Path: a byte is held in the input register, and its result word then in the result register.
// Throughput: one byte per cycle; the input and result registers stall only on sink backpressure.
// Bytes of the head and verify code give no result word.
// Reset (synchronous, active low) returns to head hunting, empties both registers
// and loads the register defaults (limit 256, all others zero).
`timescale 1ns / 1ps

module length_prefixed_packet_deframer #(
    parameter int VERIFY_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lpd_rx_if.sink            i_rx,
    lpd_res_if.source         o_res,
    input  logic              i_cfg_we,
    input  lpd_pkg::t_cfg_idx i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    import lpd_pkg::*;

    t_cfg              w_cfg;
    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_byte;
    logic              w_adv;
    logic              w_res_valid;
    t_result           w_res;
    logic              w_out_free;
    logic              w_out_valid;
    t_result           w_out_res;

    // a byte with no result word never waits on the result register
    assign w_adv = w_in_valid && (!w_res_valid || w_out_free);

    lpd_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_cfg     (w_cfg)
    );

    lpd_in_stage u_in (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_rx.valid),
        .i_byte (i_rx.rx_byte),
        .o_ready(i_rx.ready),
        .i_adv  (w_adv),
        .o_valid(w_in_valid),
        .o_byte (w_in_byte)
    );

    lpd_core #(
        .VERIFY_BYTES(VERIFY_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (w_in_valid),
        .i_byte     (w_in_byte),
        .i_adv      (w_adv),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    lpd_out_stage u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_adv && w_res_valid),
        .i_res  (w_res),
        .i_ready(o_res.ready),
        .o_valid(w_out_valid),
        .o_free (w_out_free),
        .o_res  (w_out_res)
    );

    assign o_res.valid      = w_out_valid;
    assign o_res.out_byte   = w_out_res.out_byte;
    assign o_res.byte_index = w_out_res.byte_index;
    assign o_res.status     = w_out_res.status;
    assign o_res.last       = w_out_res.last;

endmodule

[hw/rtl/lpd_checker.sv]
// Port-level assertions for the deframer and the bind that attaches them.
`timescale 1ns / 1ps

module lpd_checker #(
    parameter int VERIFY_BYTES = 4
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [7:0]  i_out_byte,
    input logic [15:0] i_byte_index,
    input logic [1:0]  i_status,
    input logic        i_last
);
    import lpd_pkg::*;

    localparam logic [INDEX_W-1:0] SEQ_POS_W   = INDEX_W'(1 + VERIFY_BYTES);
    localparam logic [INDEX_W-1:0] LEN_LAST_W  = INDEX_W'(VERIFY_BYTES + 6);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result word present right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_byte) && $stable(i_byte_index)
                                && $stable(i_status) && $stable(i_last))
        else $error("stalled result word changed");

    // only words with ST_BODY status leave the packet open
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == (i_status != ST_BODY)))
        else $error("last flag disagrees with status");

    // head and verify positions never surface
    a_index_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_byte_index >= SEQ_POS_W)
        else $error("result word at a head or verify position");

    // oversize is judged on the last length byte only
    a_oversize_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_OVERSIZE |-> i_byte_index == LEN_LAST_W)
        else $error("oversize flagged away from the last length byte");

endmodule

bind length_prefixed_packet_deframer lpd_checker #(
    .VERIFY_BYTES(VERIFY_BYTES)
) u_lpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_out_byte  (o_res.out_byte),
    .i_byte_index(o_res.byte_index),
    .i_status    (o_res.status),
    .i_last      (o_res.last)
);

[tb/length_prefixed_packet_deframer_test.sv]
// Self-checking testbench for the length-prefixed packet deframer, with a byte-level predictor.
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_test;
    import lpd_pkg::*;

    localparam int CODE_LEN            = 4;
    localparam int LEN_AT              = 1 + CODE_LEN + 2;
    localparam int BODY_AT             = LEN_AT + 4;
    localparam int SETTLE_CYCLES       = 6;
    localparam int LONG_HOLD           = 200;
    localparam int STALL_LIMIT         = 2000;
    localparam int MAX_REPORTS         = 40;
    localparam int TRAFFIC_PER_SETTING = 60;

    typedef enum logic [1:0] {SEEK_HEAD, MATCH_CODE, TAKE_HEADER, TAKE_BODY} t_deframe_state;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [31:0] cfg_data;

    lpd_rx_if  rx_ch ();
    lpd_res_if res_ch ();

    length_prefixed_packet_deframer u_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_rx      (rx_ch),
        .o_res     (res_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // predictor state and register copy
    t_cfg           cfg;
    t_deframe_state fsm;
    logic [15:0]    pos;
    logic [31:0]    len_acc;
    logic [32:0]    frame_len;

    t_result     expected_words[$];
    logic [7:0]  frame_q[$];
    int          mismatches;
    int          engaged_bytes;
    bit          src_gaps;
    bit          sink_gaps;
    bit          long_hold;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void restart_hunt();
        fsm     = SEEK_HEAD;
        pos     = '0;
        len_acc = '0;
    endfunction

    function automatic logic [7:0] code_byte_at(input logic [15:0] p);
        return 8'(cfg.verify_code >> (8 * ((p - 16'd1) & 16'd7)));
    endfunction

    // Advances the predictor by one byte; returns 1 when the byte yields a result word.
    function automatic bit deframe_byte(input logic [7:0] b, output t_result w);
        logic [15:0] at;
        bit          hit;
        hit = 1'b0;
        w   = '0;
        case (fsm)
            SEEK_HEAD: begin
                if (b == cfg.head_byte) begin
                    fsm = MATCH_CODE;
                    pos = 16'd1;
                end
            end
            MATCH_CODE: begin
                if (b == code_byte_at(pos)) begin
                    pos = pos + 16'd1;
                    if (pos >= 1 + CODE_LEN) begin
                        fsm     = TAKE_HEADER;
                        len_acc = '0;
                    end
                end else if (b == cfg.head_byte) begin
                    pos = 16'd1;
                end else begin
                    restart_hunt();
                end
            end
            TAKE_HEADER: begin
                at = pos;
                if (at >= LEN_AT && at < BODY_AT)
                    len_acc = len_acc | (32'(b) << (8 * (at - LEN_AT)));
                pos          = pos + 16'd1;
                hit          = 1'b1;
                w.out_byte   = b;
                w.byte_index = at;
                w.status     = ST_BODY;
                w.last       = 1'b0;
                if (pos >= BODY_AT) begin
                    // full length computed in 33 bits so a huge length cannot wrap
                    frame_len = 33'(BODY_AT) + 33'(len_acc) + 33'd1;
                    if (frame_len > 33'(cfg.max_packet_len)) begin
                        w.status = ST_OVERSIZE;
                        w.last   = 1'b1;
                        restart_hunt();
                    end else begin
                        fsm = TAKE_BODY;
                    end
                end
            end
            default: begin
                at           = pos;
                pos          = pos + 16'd1;
                hit          = 1'b1;
                w.out_byte   = b;
                w.byte_index = at;
                w.status     = ST_BODY;
                w.last       = 1'b0;
                if (33'(at) + 33'd1 >= frame_len) begin
                    w.status = (b == cfg.tail_byte) ? ST_GOOD : ST_BAD_TAIL;
                    w.last   = 1'b1;
                    restart_hunt();
                end
            end
        endcase
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    task automatic check_word();
        t_result want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, byte", 32'(res_ch.out_byte), 32'd0);
        end else begin
            want = expected_words.pop_front();
            if (res_ch.out_byte !== want.out_byte)
                report_mismatch("out_byte", 32'(res_ch.out_byte), 32'(want.out_byte));
            if (res_ch.byte_index !== want.byte_index)
                report_mismatch("byte_index", 32'(res_ch.byte_index), 32'(want.byte_index));
            if (res_ch.status !== want.status)
                report_mismatch("status", 32'(res_ch.status), 32'(want.status));
            if (res_ch.last !== want.last)
                report_mismatch("last", 32'(res_ch.last), 32'(want.last));
        end
    endtask

    // Result side: random stall per word, plus one long hold on request.
    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = sink_gaps ? $urandom_range(0, 7) : 0;
            if (long_hold) begin
                stall     = LONG_HOLD;
                long_hold = 1'b0;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (res_ch.valid !== 1'b1) @(posedge clk);
            check_word();
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int      gap;
        t_result w;
        gap = src_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (rx_ch.ready !== 1'b1) @(posedge clk);
        if (fsm != SEEK_HEAD || b == cfg.head_byte)
            engaged_bytes++;
        if (deframe_byte(b, w))
            expected_words.push_back(w);
    endtask

    task automatic drain_and_settle();
        rx_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        // head and code bytes give no word, so let the pipeline empty
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Feed filler until the predictor is back at head hunting.
    task automatic flush_to_hunt();
        logic [7:0] v;
        while (fsm != SEEK_HEAD) begin
            v = 8'($urandom);
            if (fsm == MATCH_CODE)
                while (v == code_byte_at(pos) || v == cfg.head_byte) v = 8'($urandom);
            send_byte(v);
        end
    endtask

    task automatic set_config(input logic [7:0] head, input logic [31:0] code,
                              input logic [7:0] tail, input logic [15:0] limit);
        flush_to_hunt();
        drain_and_settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HEAD;
        cfg_data <= {24'd0, head};
        @(posedge clk);
        cfg_idx  <= CFG_VERIFY;
        cfg_data <= code;
        @(posedge clk);
        cfg_idx  <= CFG_TAIL;
        cfg_data <= {24'd0, tail};
        @(posedge clk);
        cfg_idx  <= CFG_MAXLEN;
        cfg_data <= {16'd0, limit};
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg.head_byte      = head;
        cfg.verify_code    = code;
        cfg.tail_byte      = tail;
        cfg.max_packet_len = limit;
    endtask

    // Oversize frames stop after the last length byte.
    task automatic build_frame(input logic [31:0] len, input bit tail_ok);
        frame_q.delete();
        frame_q.push_back(cfg.head_byte);
        for (int i = 0; i < CODE_LEN; i++)
            frame_q.push_back(cfg.verify_code[8*i +: 8]);
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'($urandom));
        for (int i = 0; i < 4; i++)
            frame_q.push_back(len[8*i +: 8]);
        if (33'(len) + 33'(BODY_AT + 1) <= 33'(cfg.max_packet_len)) begin
            for (int j = 0; j < len; j++)
                frame_q.push_back(8'($urandom));
            frame_q.push_back(tail_ok ? cfg.tail_byte
                                      : cfg.tail_byte ^ 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_frame_range(input int from, input int upto);
        for (int i = from; i < upto; i++)
            send_byte(frame_q[i]);
    endtask

    task automatic run_traffic(input int budget);
        int          kind;
        int          n;
        int          fit;
        int          start_count;
        logic [31:0] len;
        start_count = engaged_bytes;
        while (engaged_bytes - start_count < budget) begin
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            kind      = $urandom_range(0, 9);
            if (kind == 7) begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_byte(($urandom_range(0, 3) == 0) ? cfg.head_byte : 8'($urandom));
            end else begin
                fit = int'(cfg.max_packet_len) - (BODY_AT + 1);
                if (fit >= 0 && $urandom_range(0, 4) != 0)
                    len = $urandom_range(0, (fit < 24) ? fit : 24);
                else if ($urandom_range(0, 1) != 0)
                    len = fit + 1 + $urandom_range(0, 3);
                else
                    len = $urandom | 32'h0001_0000;
                build_frame(len, $urandom_range(0, 3) != 0);
                if (kind == 8) begin
                    n = $urandom_range(1, frame_q.size() - 1);
                    while (frame_q.size() > n) void'(frame_q.pop_back());
                end else if (kind == 9) begin
                    // damage a code byte, a sequence byte or the tail, never the length
                    n = (frame_q.size() > BODY_AT && $urandom_range(0, 1) != 0)
                        ? frame_q.size() - 1 : $urandom_range(1, 6);
                    frame_q[n] = frame_q[n] ^ 8'($urandom_range(1, 255));
                end
                send_frame_range(0, frame_q.size());
            end
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_reset_defaults();
        build_frame(32'd3, 1'b1);
        frame_q[5]  = 8'hFF;
        frame_q[6]  = 8'h00;
        frame_q[11] = 8'hFF;
        frame_q[12] = 8'h80;
        frame_q[13] = 8'h01;
        send_frame_range(0, frame_q.size());
        build_frame(32'd0, 1'b0);
        send_frame_range(0, frame_q.size());
    endtask

    task automatic test_code_resync();
        set_config(8'hA5, 32'h1234_5678, 8'h5A, 16'd64);
        // head value inside the code restarts the packet at the head
        send_byte(8'hA5);
        send_byte(8'h78);
        send_byte(8'hA5);
        build_frame(32'd2, 1'b1);
        send_frame_range(1, frame_q.size());
        // any other wrong code byte goes back to hunting
        send_byte(8'hA5);
        send_byte(8'h78);
        send_byte(8'h56);
        send_byte(8'h00);
        build_frame(32'd1, 1'b1);
        send_frame_range(0, frame_q.size());
    endtask

    task automatic test_length_limit();
        set_config(8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'd12);
        build_frame(32'd0, 1'b1);
        send_frame_range(0, frame_q.size());
        build_frame(32'd1, 1'b1);
        send_frame_range(0, frame_q.size());
        // limit under the smallest frame: everything is oversize
        set_config(8'h00, 32'h0000_0000, 8'h00, 16'd11);
        build_frame(32'd0, 1'b1);
        send_frame_range(0, frame_q.size());
        set_config(8'h3C, 32'hDEAD_BEEF, 8'hC3, 16'hFFFF);
        build_frame(32'hFFFF_FFFF, 1'b1);
        send_frame_range(0, frame_q.size());
        build_frame(32'd65524, 1'b1);
        send_frame_range(0, frame_q.size());
    endtask

    task automatic test_longest_frame();
        // frame exactly at the limit, sent back to back
        set_config(8'h3C, 32'hDEAD_BEEF, 8'hC3, 16'd64);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        build_frame(32'd52, 1'b1);
        send_frame_range(0, frame_q.size());
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_sink_hold();
        set_config(8'h55, 32'h0102_0304, 8'hAA, 16'd200);
        src_gaps  = 1'b0;
        long_hold = 1'b1;
        build_frame(32'd80, 1'b1);
        send_frame_range(0, frame_q.size());
        src_gaps = 1'b1;
    endtask

    task automatic test_source_pause();
        build_frame(32'd20, 1'b1);
        send_frame_range(0, 14);
        drain_and_settle();
        send_frame_range(14, frame_q.size());
    endtask

    task automatic test_random_traffic();
        set_config(8'h00, 32'h0000_0000, 8'hFF, 16'd40);
        run_traffic(TRAFFIC_PER_SETTING);
        set_config(8'hFF, 32'hFFFF_FFFF, 8'h00, 16'd12);
        run_traffic(TRAFFIC_PER_SETTING);
        set_config(8'($urandom), $urandom, 8'($urandom), 16'hFFFF);
        run_traffic(TRAFFIC_PER_SETTING);
        set_config(8'($urandom), $urandom, 8'($urandom), 16'($urandom_range(12, 80)));
        run_traffic(TRAFFIC_PER_SETTING);
        set_config(8'h7E, 32'h7E7E_7E7E, 8'h7E, 16'd48);
        run_traffic(TRAFFIC_PER_SETTING);
        set_config(8'($urandom), $urandom, 8'($urandom), 16'd30);
        run_traffic(TRAFFIC_PER_SETTING);
    endtask

    initial begin
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_HEAD;
        cfg_data      <= 32'd0;
        mismatches    = 0;
        engaged_bytes = 0;
        src_gaps      = 1'b1;
        sink_gaps     = 1'b1;
        long_hold     = 1'b0;
        cfg.head_byte      = 8'h00;
        cfg.verify_code    = 32'h0;
        cfg.tail_byte      = 8'h00;
        cfg.max_packet_len = MAXLEN_RESET;
        frame_len = '0;
        restart_hunt();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_code_resync();
        test_length_limit();
        test_longest_frame();
        test_sink_hold();
        test_source_pause();
        test_random_traffic();
        drain_and_settle();

        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
